// ===== rtl/url_percent_codec_macros.svh =====
// assertion macros shared by the codec modules
`ifndef URL_PERCENT_CODEC_MACROS_SVH
`define URL_PERCENT_CODEC_MACROS_SVH

// same-cycle implication, checked out of reset
`define UPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/upc_pkg.sv =====
package upc_pkg;

  // register map
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_DIRECTION = 1'b0;

  // direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // characters with a special role
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // decoder escape progress
  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upc_phase_t;

  // up to three result bytes for one input word
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            last;
  } upc_res_t;

  // hex digit of either case: valid flag on top, value below
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // upper-case hex character for a nibble
  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

  // characters that pass through the encoder unchanged
  function automatic logic is_unreserved(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                     8'h2D, 8'h2E, 8'h5F, 8'h7E};
  endfunction

endpackage

// ===== rtl/upc_cfg.sv =====
module upc_cfg
  import upc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic              direction
);

  logic dir_r;
  logic dir_nxt;
  logic hit;

  // register index sits above the byte offset
  assign hit    = (paddr[ADDR_W-1:2] == REG_DIRECTION);
  assign pready = 1'b1;

  // write decode
  always_comb begin
    dir_nxt = dir_r;
    if (psel && penable && pwrite && hit) begin
      dir_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENCODE;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  // read back
  assign prdata    = hit ? {{(DATA_W-1){1'b0}}, dir_r} : '0;
  assign direction = dir_r;

endmodule

// ===== rtl/upc_xlate.sv =====
`include "url_percent_codec_macros.svh"

module upc_xlate
  import upc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       direction,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output upc_res_t   res
);

  upc_phase_t phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  logic [4:0] c_hex, h_hex;
  logic [7:0] pl_byte;
  logic       pl_n, pl_esc, plain;
  logic [1:0] pfx_n;

  // translate one word against the escape state
  always_comb begin
    res       = '0;
    phase_nxt = PH_NONE;
    held_nxt  = '0;
    c_hex     = hex_dec(in_byte);
    h_hex     = hex_dec(held_r);
    pfx_n     = 2'd0;
    plain     = 1'b1;

    // byte handled with nothing pending
    pl_byte = in_byte;
    pl_n    = 1'b1;
    pl_esc  = 1'b0;
    if (in_byte == CH_PCT) begin
      if (!in_last) begin
        pl_n   = 1'b0;
        pl_esc = 1'b1;
      end
    end else if (in_byte == CH_PLUS) begin
      pl_byte = CH_SPACE;
    end

    if (direction == DIR_ENCODE) begin
      plain = 1'b0;
      if (is_unreserved(in_byte)) begin
        res.data[0] = in_byte;
        res.count   = 2'd1;
      end else if (in_byte == CH_SPACE) begin
        res.data[0] = CH_PLUS;
        res.count   = 2'd1;
      end else begin
        res.data[0] = CH_PCT;
        res.data[1] = hex_upper(in_byte[7:4]);
        res.data[2] = hex_upper(in_byte[3:0]);
        res.count   = 2'd3;
      end
    end else begin
      case (phase_r)
        PH_PCT: begin
          if (c_hex[4]) begin
            plain = 1'b0;
            if (in_last) begin
              res.data[0] = CH_PCT;
              res.data[1] = in_byte;
              res.count   = 2'd2;
            end else begin
              phase_nxt = PH_DIGIT;
              held_nxt  = in_byte;
            end
          end else begin
            pfx_n = 2'd1;
          end
        end
        PH_DIGIT: begin
          if (h_hex[4] && c_hex[4]) begin
            plain       = 1'b0;
            res.data[0] = {h_hex[3:0], c_hex[3:0]};
            res.count   = 2'd1;
          end else begin
            pfx_n = 2'd2;
          end
        end
        default: ;
      endcase

      // literal flush of a broken escape, then the byte itself
      if (plain) begin
        if (pfx_n != 2'd0) begin
          res.data[0] = CH_PCT;
        end
        if (pfx_n == 2'd2) begin
          res.data[1] = held_r;
        end
        case (pfx_n)
          2'd0:    res.data[0] = pl_byte;
          2'd1:    res.data[1] = pl_byte;
          default: res.data[2] = pl_byte;
        endcase
        res.count = pfx_n + {1'b0, pl_n};
        if (pl_esc) begin
          phase_nxt = PH_PCT;
        end
      end
    end
    res.last = in_last;
  end

  // escape state advances only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  `UPC_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_last,
    phase_r == PH_NONE && held_r == 8'd0, "escape state left after end of string")
  `UPC_ASSERT_NOW(a_last_emits, clk, rst_n, accept && in_last,
    res.count != 2'd0, "end of string word produced no byte")
  `UPC_ASSERT_NEXT(a_enc_idle, clk, rst_n, accept && direction == DIR_ENCODE,
    phase_r == PH_NONE, "escape pending after an encoded word")

endmodule

// ===== rtl/upc_out.sv =====
`include "url_percent_codec_macros.svh"

module upc_out
  import upc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  upc_res_t   res,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);

  logic [2:0][7:0] data_r;
  logic [1:0]      cnt_r;
  logic [1:0]      idx_r, idx_nxt;
  logic            last_r;
  logic            valid_r, valid_nxt;
  logic            pop, run_last;

  // current byte of the held result
  always_comb begin
    case (idx_r)
      2'd0:    out_byte = data_r[0];
      2'd1:    out_byte = data_r[1];
      default: out_byte = data_r[2];
    endcase
  end

  assign run_last       = (idx_r == cnt_r - 2'd1);
  assign pop            = valid_r && out_ready;
  assign free           = !valid_r || (pop && run_last);
  assign out_valid      = valid_r;
  assign out_run_last   = run_last;
  assign out_string_end = run_last && last_r;

  // buffer control
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load && res.count != 2'd0) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (pop && run_last) begin
      valid_nxt = 1'b0;
    end else if (pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && res.count != 2'd0) begin
      data_r <= res.data;
      cnt_r  <= res.count;
      last_r <= res.last;
    end
  end

  `UPC_ASSERT_NOW(a_idx_range, clk, rst_n, valid_r,
    cnt_r != 2'd0 && idx_r < cnt_r, "byte index outside held result")
  `UPC_ASSERT_NEXT(a_idx_step, clk, rst_n, pop && !run_last,
    valid_r && idx_r == $past(idx_r) + 2'd1, "result dropped before its last byte")
  `UPC_ASSERT_NEXT(a_load_start, clk, rst_n, load && res.count != 2'd0,
    valid_r && idx_r == 2'd0, "new result does not start at its first byte")

endmodule

// ===== rtl/url_percent_codec.sv =====
// Streaming form-URL codec: one source byte per input word, tagged with in_last on
// the final byte of a string; the direction register (address 0, bit 0) picks
// encoding (0) or percent decoding (1); the user must write it only while the
// block is idle, as the block itself does not enforce this. Each accepted word
// is translated in the cycle it arrives and its results land in a result register,
// which then drives one byte per cycle while out_ready is high; a word giving no
// bytes leaves the register empty. The next word is taken while the register is
// empty or in the cycle the last byte of the held result leaves. out_run_last
// marks the final byte of each word's results, out_string_end that of a string.

module url_percent_codec
  import upc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_string_end
);

  logic     direction;
  logic     accept;
  logic     free;
  upc_res_t res;

  assign in_ready = free;
  assign accept   = in_valid && free;

  // direction register
  upc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .direction (direction)
  );

  // translation and escape state
  upc_xlate u_xlate (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (direction),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .res       (res)
  );

  // result register and byte sequencing
  upc_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .res            (res),
    .free           (free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule
